@@ rtl/nmea_rmc_time_extractor_top_defines.svh @@
// assertion macros for the rmc time extractor
// assumes the asserting module has clk and rst_n in scope
`ifndef NMEA_RMC_TIME_EXTRACTOR_TOP_DEFINES_SVH
`define NMEA_RMC_TIME_EXTRACTOR_TOP_DEFINES_SVH

// property checked on every clock outside reset
`define NRTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock outside reset
`define NRTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define NRTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/nrte_pkg.sv @@
// shared types and constants for the rmc time extractor
// no dependencies
`default_nettype none

package nrte_pkg;

  // default packet geometry
  localparam int PACKET_SIZE_DEF  = 512;
  localparam int START_OFFSET_DEF = 206;

  // byte position counter
  localparam int          POS_W   = 10;
  localparam logic [9:0]  POS_MAX = 10'd1023;

  // capture slot pointer codes
  localparam logic [2:0] OFF_DONE = 3'd6;
  localparam logic [2:0] OFF_IDLE = 3'd7;

  // character codes
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_V     = 8'h56;

  // comma numbers of interest
  localparam logic [3:0] COMMA_TIME  = 4'd1;
  localparam logic [3:0] COMMA_VALID = 4'd2;
  localparam logic [3:0] COMMA_DATE  = 4'd9;

  // depth of the packet record queue
  localparam int REC_DEPTH = 2;

  typedef enum logic [1:0] {
    PH_SCANNING = 2'd0,
    PH_FOUND    = 2'd1,
    PH_STOPPED  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FIX_BAD  = 2'd1,
    ST_NO_DATE  = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  // one finished packet as handed from front to back
  typedef struct packed {
    logic             fix_bad;
    logic             found;
    logic [5:0][7:0]  tch;
    logic [5:0][7:0]  dch;
  } rec_t;

endpackage

`default_nettype wire

@@ rtl/nrte_front.sv @@
// byte scanner: counts commas, captures time and date characters
// depends on nrte_pkg
`default_nettype none

module nrte_front #(
  parameter int PACKET_SIZE  = nrte_pkg::PACKET_SIZE_DEF,
  parameter int START_OFFSET = nrte_pkg::START_OFFSET_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          beat,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  output logic               rec_push,
  output nrte_pkg::rec_t     rec
);
  import nrte_pkg::*;

  localparam logic [POS_W-1:0] START_POS = POS_W'(START_OFFSET + 1);
  localparam logic [POS_W-1:0] LIMIT_POS = POS_W'(PACKET_SIZE - 6);

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [3:0]         cc_r, cc_nxt;
  logic               fail_r, fail_nxt;
  logic               vpend_r, vpend_nxt;
  logic [2:0]         toff_r, toff_nxt;
  logic [2:0]         doff_r, doff_nxt;
  logic [5:0][7:0]    tch_r, tch_nxt;
  logic [5:0][7:0]    dch_r, dch_nxt;

  // state registers, cleared by reset and after each last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SCANNING;
      pos_r   <= '0;
      cc_r    <= '0;
      fail_r  <= 1'b0;
      vpend_r <= 1'b0;
      toff_r  <= OFF_IDLE;
      doff_r  <= OFF_IDLE;
    end else if (beat) begin
      if (last_byte) begin
        phase_r <= PH_SCANNING;
        pos_r   <= '0;
        cc_r    <= '0;
        fail_r  <= 1'b0;
        vpend_r <= 1'b0;
        toff_r  <= OFF_IDLE;
        doff_r  <= OFF_IDLE;
      end else begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        cc_r    <= cc_nxt;
        fail_r  <= fail_nxt;
        vpend_r <= vpend_nxt;
        toff_r  <= toff_nxt;
        doff_r  <= doff_nxt;
      end
    end
  end

  // captured characters
  always_ff @(posedge clk) begin
    if (beat) begin
      tch_r <= tch_nxt;
      dch_r <= dch_nxt;
    end
  end

  // per-byte next state
  always_comb begin
    phase_nxt = phase_r;
    cc_nxt    = cc_r;
    fail_nxt  = fail_r;
    vpend_nxt = vpend_r;
    toff_nxt  = toff_r;
    doff_nxt  = doff_r;
    tch_nxt   = tch_r;
    dch_nxt   = dch_r;
    pos_nxt   = (pos_r != POS_MAX) ? pos_r + 1'b1 : pos_r;

    // fix validity byte right after the second comma
    if (vpend_r) begin
      if (data_byte == CH_V) begin
        fail_nxt = 1'b1;
      end
      vpend_nxt = 1'b0;
    end

    // time and date capture slots
    if (toff_r < OFF_DONE) begin
      tch_nxt[toff_r] = data_byte;
      toff_nxt        = toff_r + 1'b1;
    end
    if (doff_r < OFF_DONE) begin
      dch_nxt[doff_r] = data_byte;
      doff_nxt        = doff_r + 1'b1;
    end

    // comma scan
    unique case (phase_r)
      PH_SCANNING: begin
        if (pos_r >= START_POS) begin
          if (pos_r >= LIMIT_POS) begin
            phase_nxt = PH_STOPPED;
          end else if (data_byte == CH_STAR) begin
            phase_nxt = PH_STOPPED;
          end else if (data_byte == CH_COMMA) begin
            cc_nxt = cc_r + 1'b1;
            if (cc_nxt == COMMA_TIME) begin
              toff_nxt = '0;
            end else if (cc_nxt == COMMA_VALID) begin
              vpend_nxt = 1'b1;
            end else if (cc_nxt == COMMA_DATE) begin
              doff_nxt  = '0;
              phase_nxt = PH_FOUND;
            end
          end
        end
      end
      PH_FOUND, PH_STOPPED: begin
        phase_nxt = phase_r;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // packet record on the last byte
  assign rec_push    = beat & last_byte;
  assign rec.fix_bad = fail_nxt;
  assign rec.found   = (phase_nxt == PH_FOUND) && (doff_nxt == OFF_DONE) &&
                       (toff_nxt == OFF_DONE);
  assign rec.tch     = tch_nxt;
  assign rec.dch     = dch_nxt;

endmodule

`default_nettype wire

@@ rtl/nrte_rec_fifo.sv @@
// two-entry queue of packet records between scanner and decoder
// depends on nrte_pkg and the assertion macro header
`default_nettype none

module nrte_rec_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire nrte_pkg::rec_t  wr_rec,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output nrte_pkg::rec_t       rd_rec
);
  import nrte_pkg::*;
`include "nmea_rmc_time_extractor_top_defines.svh"

  localparam int PTR_W = $clog2(REC_DEPTH);
  localparam int CNT_W = $clog2(REC_DEPTH + 1);

  rec_t              mem_r [REC_DEPTH];
  logic [PTR_W-1:0]  wp_r, rp_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(REC_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_rec  = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PTR_W'(REC_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PTR_W'(REC_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_rec;
    end
  end

  // count stays within depth
  `NRTE_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(REC_DEPTH), "record queue over depth")
  // empty queue has aligned pointers
  `NRTE_ASSERT_IMP(a_empty_ptr, cnt_r == '0, wp_r == rp_r, "pointer mismatch when empty")
  // a lone push raises the count by one
  `NRTE_ASSERT_NXT(a_push_cnt, do_push && !do_pop, cnt_r == $past(cnt_r) + 1'b1,
    "push did not raise count")

endmodule

`default_nettype wire

@@ rtl/nrte_back.sv @@
// decoder: turns a packet record into status and date/time values
// depends on nrte_pkg
`default_nettype none

module nrte_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            rec_avail,
  input  wire nrte_pkg::rec_t  rec,
  output logic                 rec_pop,
  input  wire logic            res_pop,
  output logic                 res_empty,
  output logic [1:0]           status,
  output logic [6:0]           year,
  output logic [3:0]           month,
  output logic [4:0]           day,
  output logic [4:0]           hour,
  output logic [5:0]           minute,
  output logic [5:0]           second
);
  import nrte_pkg::*;

  // (hi-48)*10 + (lo-48), range -528..2277
  function automatic logic signed [12:0] two_dig(input logic [7:0] hi, input logic [7:0] lo);
    logic signed [12:0] h;
    logic signed [12:0] l;
    h = $signed({5'b0, hi}) - 13'sd48;
    l = $signed({5'b0, lo}) - 13'sd48;
    return (h <<< 3) + (h <<< 1) + l;
  endfunction

  logic               val_r;
  status_t            st_r, st_nxt;
  logic [6:0]         yr_r;
  logic [3:0]         mo_r;
  logic [4:0]         dy_r, hr_r;
  logic [5:0]         mi_r, se_r;
  logic signed [12:0] yr, mo, dy, hr, mi, se;
  logic               in_range;

  assign rec_pop = rec_avail & (~val_r | res_pop);

  // decode the head record
  always_comb begin
    yr = two_dig(rec.dch[4], rec.dch[5]);
    mo = two_dig(rec.dch[2], rec.dch[3]);
    dy = two_dig(rec.dch[0], rec.dch[1]);
    hr = two_dig(rec.tch[0], rec.tch[1]);
    mi = two_dig(rec.tch[2], rec.tch[3]);
    se = two_dig(rec.tch[4], rec.tch[5]);
    in_range = (yr >= 13'sd0) && (yr <= 13'sd99) &&
               (mo >= 13'sd1) && (mo <= 13'sd12) &&
               (dy >= 13'sd1) && (dy <= 13'sd31) &&
               (hr >= 13'sd0) && (hr <= 13'sd23) &&
               (mi >= 13'sd0) && (mi <= 13'sd59) &&
               (se >= 13'sd0) && (se <= 13'sd59);
    if (rec.fix_bad) begin
      st_nxt = ST_FIX_BAD;
    end else if (!rec.found) begin
      st_nxt = ST_NO_DATE;
    end else if (!in_range) begin
      st_nxt = ST_RANGE;
    end else begin
      st_nxt = ST_OK;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
    end else if (rec_pop) begin
      val_r <= 1'b1;
    end else if (res_pop) begin
      val_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (rec_pop) begin
      st_r <= st_nxt;
      if (st_nxt == ST_OK) begin
        yr_r <= yr[6:0];
        mo_r <= mo[3:0];
        dy_r <= dy[4:0];
        hr_r <= hr[4:0];
        mi_r <= mi[5:0];
        se_r <= se[5:0];
      end else begin
        yr_r <= '0;
        mo_r <= '0;
        dy_r <= '0;
        hr_r <= '0;
        mi_r <= '0;
        se_r <= '0;
      end
    end
  end

  assign res_empty = ~val_r;
  assign status    = st_r;
  assign year      = yr_r;
  assign month     = mo_r;
  assign day       = dy_r;
  assign hour      = hr_r;
  assign minute    = mi_r;
  assign second    = se_r;

endmodule

`default_nettype wire

@@ rtl/nmea_rmc_time_extractor_top.sv @@
// top level of the rmc time extractor: scanner, record queue, decoder
// depends on nrte_pkg, nrte_front, nrte_rec_fifo, nrte_back
`default_nettype none

// Takes one positioning packet a byte per beat and, on the beat marked
// last, yields one result with status and the decoded date and time. Bytes
// are taken one per cycle unless full is high; the scanner does all per-byte
// work in that cycle and hands a finished packet record to a two-entry queue.
// The decoder turns the head record into a registered result once the result
// register is free or being popped; the result then shows on the out_ ports.
// full rises only when both queue entries and the result register are
// occupied, i.e. after the result side has stalled for several packets.

module nmea_rmc_time_extractor_top #(
  parameter int PACKET_SIZE  = nrte_pkg::PACKET_SIZE_DEF,
  parameter int START_OFFSET = nrte_pkg::START_OFFSET_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic        push,
  output logic             full,
  output logic [1:0]       out_status,
  output logic [6:0]       out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic             empty,
  input  wire logic        pop
);
  import nrte_pkg::*;

  logic  beat;
  logic  rec_push;
  rec_t  rec_wr;
  rec_t  rec_rd;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  assign full = q_full;
  assign beat = push & ~q_full;

  // byte scanner
  nrte_front #(
    .PACKET_SIZE  (PACKET_SIZE),
    .START_OFFSET (START_OFFSET)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .rec_push  (rec_push),
    .rec       (rec_wr)
  );

  // record queue
  nrte_rec_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (rec_push),
    .wr_rec (rec_wr),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_rec (rec_rd)
  );

  // decoder and result register
  nrte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_avail (~q_empty),
    .rec       (rec_rd),
    .rec_pop   (q_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .status    (out_status),
    .year      (out_year),
    .month     (out_month),
    .day       (out_day),
    .hour      (out_hour),
    .minute    (out_minute),
    .second    (out_second)
  );

endmodule

`default_nettype wire

@@ tb/rmc_time_checker.sv @@
// result checker for the rmc time extractor: follows every accepted byte,
// predicts each packet's status and decoded date/time, compares popped beats
// depends on nrte_pkg

module rmc_time_checker #(
  parameter int PACKET_SIZE  = nrte_pkg::PACKET_SIZE_DEF,
  parameter int START_OFFSET = nrte_pkg::START_OFFSET_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       push,
  input  logic       full,
  input  logic [1:0] out_status,
  input  logic [6:0] out_year,
  input  logic [3:0] out_month,
  input  logic [4:0] out_day,
  input  logic [4:0] out_hour,
  input  logic [5:0] out_minute,
  input  logic [5:0] out_second,
  input  logic       empty,
  input  logic       pop,
  output int         mismatches,
  output int         results_due,
  output int         ok_count,
  output int         fix_count,
  output int         nodate_count,
  output int         range_count
);
  import nrte_pkg::*;

  typedef struct {
    status_t    status;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } rmc_time_t;

  // predicted scanner state for the packet in flight
  logic [9:0]      byte_pos;
  logic [3:0]      comma_cnt;
  phase_t          phase;
  logic            fix_bad;
  logic [2:0]      time_slot;
  logic [2:0]      date_slot;
  logic            check_fix;
  logic [5:0][7:0] time_ch;
  logic [5:0][7:0] date_ch;

  rmc_time_t expected_times[$];

  task automatic clear_packet();
    byte_pos  = '0;
    comma_cnt = '0;
    phase     = PH_SCANNING;
    fix_bad   = 1'b0;
    time_slot = OFF_IDLE;
    date_slot = OFF_IDLE;
    check_fix = 1'b0;
    time_ch   = '0;
    date_ch   = '0;
  endtask

  // two ascii characters as a signed decimal pair
  function automatic int pair_value(logic [7:0] hi, logic [7:0] lo);
    return (int'(hi) - 48) * 10 + (int'(lo) - 48);
  endfunction

  task automatic report(string what, int got, int want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    end
  endtask

  // advance the prediction by one byte; queue a result on the last byte
  task automatic decode_rmc_byte(logic [7:0] b, logic last);
    rmc_time_t r;
    int        yr, mo, dy, hr, mi, se;
    logic [9:0] p;
    p = byte_pos;
    // the byte right after comma 2 is the fix flag
    if (check_fix) begin
      if (b == CH_V) fix_bad = 1'b1;
      check_fix = 1'b0;
    end
    if (time_slot < OFF_DONE) begin
      time_ch[time_slot] = b;
      time_slot++;
    end
    if (date_slot < OFF_DONE) begin
      date_ch[date_slot] = b;
      date_slot++;
    end
    // comma scan inside the window
    if (phase == PH_SCANNING && int'(p) >= START_OFFSET + 1) begin
      if (int'(p) >= PACKET_SIZE - 6) begin
        phase = PH_STOPPED;
      end else if (b == CH_STAR) begin
        phase = PH_STOPPED;
      end else if (b == CH_COMMA) begin
        comma_cnt++;
        if (comma_cnt == COMMA_TIME) begin
          time_slot = '0;
        end else if (comma_cnt == COMMA_VALID) begin
          check_fix = 1'b1;
        end else if (comma_cnt == COMMA_DATE) begin
          date_slot = '0;
          phase     = PH_FOUND;
        end
      end
    end
    if (byte_pos != POS_MAX) byte_pos++;
    if (!last) return;

    r.status = ST_OK;
    r.year   = '0;
    r.month  = '0;
    r.day    = '0;
    r.hour   = '0;
    r.minute = '0;
    r.second = '0;
    if (fix_bad) begin
      r.status = ST_FIX_BAD;
    end else if (phase != PH_FOUND || date_slot != OFF_DONE || time_slot != OFF_DONE) begin
      r.status = ST_NO_DATE;
    end else begin
      dy = pair_value(date_ch[0], date_ch[1]);
      mo = pair_value(date_ch[2], date_ch[3]);
      yr = pair_value(date_ch[4], date_ch[5]);
      hr = pair_value(time_ch[0], time_ch[1]);
      mi = pair_value(time_ch[2], time_ch[3]);
      se = pair_value(time_ch[4], time_ch[5]);
      if (yr < 0 || yr > 99 || mo < 1 || mo > 12 || dy < 1 || dy > 31 ||
          hr < 0 || hr > 23 || mi < 0 || mi > 59 || se < 0 || se > 59) begin
        r.status = ST_RANGE;
      end else begin
        r.year   = 7'(yr);
        r.month  = 4'(mo);
        r.day    = 5'(dy);
        r.hour   = 5'(hr);
        r.minute = 6'(mi);
        r.second = 6'(se);
      end
    end
    expected_times.push_back(r);
    clear_packet();
  endtask

  // compare one popped beat with the oldest prediction
  task automatic check_result();
    rmc_time_t e;
    if (expected_times.size() == 0) begin
      report("unexpected result status", int'(out_status), -1);
      return;
    end
    e = expected_times.pop_front();
    case (e.status)
      ST_OK:      ok_count++;
      ST_FIX_BAD: fix_count++;
      ST_NO_DATE: nodate_count++;
      default:    range_count++;
    endcase
    if (out_status !== e.status) report("status", int'(out_status), int'(e.status));
    if (out_year   !== e.year)   report("year", int'(out_year), int'(e.year));
    if (out_month  !== e.month)  report("month", int'(out_month), int'(e.month));
    if (out_day    !== e.day)    report("day", int'(out_day), int'(e.day));
    if (out_hour   !== e.hour)   report("hour", int'(out_hour), int'(e.hour));
    if (out_minute !== e.minute) report("minute", int'(out_minute), int'(e.minute));
    if (out_second !== e.second) report("second", int'(out_second), int'(e.second));
  endtask

  // byte side first so a same-edge result always finds its prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_packet();
      expected_times.delete();
      mismatches   = 0;
      ok_count     = 0;
      fix_count    = 0;
      nodate_count = 0;
      range_count  = 0;
    end else begin
      if (push && !full) decode_rmc_byte(in_data_byte, in_last_byte);
      if (pop && !empty) check_result();
    end
    results_due = expected_times.size();
  end

endmodule

@@ tb/tb_nmea_rmc_time_extractor_top.sv @@
// testbench top for the rmc time extractor: clock, reset, packet stimulus
// and result-side stalls; depends on nrte_pkg, the block and rmc_time_checker

module tb_nmea_rmc_time_extractor_top;
  import nrte_pkg::*;

  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic [7:0] in_data_byte = '0;
  logic       in_last_byte = 1'b0;
  logic       push         = 1'b0;
  logic       pop          = 1'b0;
  logic       full;
  logic       empty;
  logic [1:0] out_status;
  logic [6:0] out_year;
  logic [3:0] out_month;
  logic [4:0] out_day;
  logic [4:0] out_hour;
  logic [5:0] out_minute;
  logic [5:0] out_second;

  int mismatches, results_due;
  int ok_count, fix_count, nodate_count, range_count;

  // packet under construction and where its time and date digits sit
  logic [7:0] pkt[$];
  int         time_at;
  int         date_at;
  int         bytes_sent   = 0;
  int         packets_sent = 0;
  int         rmc_sent     = 0;
  bit         burst        = 1'b0;

  nmea_rmc_time_extractor_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .push(push), .full(full),
    .out_status(out_status), .out_year(out_year), .out_month(out_month),
    .out_day(out_day), .out_hour(out_hour), .out_minute(out_minute),
    .out_second(out_second), .empty(empty), .pop(pop)
  );

  rmc_time_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .push(push), .full(full),
    .out_status(out_status), .out_year(out_year), .out_month(out_month),
    .out_day(out_day), .out_hour(out_hour), .out_minute(out_minute),
    .out_second(out_second), .empty(empty), .pop(pop),
    .mismatches(mismatches), .results_due(results_due),
    .ok_count(ok_count), .fix_count(fix_count),
    .nodate_count(nodate_count), .range_count(range_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timed out with %0d results outstanding", results_due);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // packet building
  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
  endfunction

  function automatic void put_two(int v);
    pkt.push_back(8'(48 + v / 10));
    pkt.push_back(8'(48 + v % 10));
  endfunction

  // field filler that never holds a comma or a star
  function automatic void put_plain(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 2))
        0:       pkt.push_back(8'(48 + $urandom_range(0, 9)));
        1:       pkt.push_back(8'(65 + $urandom_range(0, 25)));
        default: pkt.push_back(8'h2E);
      endcase
    end
  endfunction

  // rmc sentence after START_OFFSET; fw < 0 gives random field widths
  function automatic void make_rmc(int lead, int hh, int mi, int ss, int dd, int mo, int yy,
                                   logic [7:0] fix, bit star_early, int fw);
    pkt.delete();
    repeat (START_OFFSET_DEF + 1) pkt.push_back(8'($urandom));
    put_plain(lead);
    put_text("$GPRMC,");
    time_at = pkt.size();
    put_two(hh);
    put_two(mi);
    put_two(ss);
    put_text(".00,");
    pkt.push_back(fix);
    for (int k = 0; k < 6; k++) begin
      pkt.push_back(CH_COMMA);
      put_plain(fw < 0 ? $urandom_range(0, 6) : fw);
      if (star_early && k == 3) pkt.push_back(CH_STAR);
    end
    pkt.push_back(CH_COMMA);
    date_at = pkt.size();
    put_two(dd);
    put_two(mo);
    put_two(yy);
    put_text(",,A*5C");
    pkt.push_back(8'h0D);
    pkt.push_back(8'h0A);
  endfunction

  // cut or pad the packet to n bytes
  function automatic void set_length(int n);
    while (pkt.size() < n) pkt.push_back(8'($urandom));
    while (pkt.size() > n) void'(pkt.pop_back());
  endfunction

  // biased junk with commas, stars and 'V'
  function automatic void make_noise(int n);
    pkt.delete();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0, 1:    pkt.push_back(CH_COMMA);
        2:       pkt.push_back(CH_STAR);
        3:       pkt.push_back(CH_V);
        4:       pkt.push_back(8'(48 + $urandom_range(0, 9)));
        default: pkt.push_back(8'($urandom));
      endcase
    end
  endfunction

  // one beat per byte, random gaps unless this packet is a burst
  task automatic send_packet();
    int n;
    for (int i = 0; i < pkt.size(); i++) begin
      n = burst ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        push <= 1'b0;
        repeat (n) @(negedge clk);
      end
      push         <= 1'b1;
      in_data_byte <= pkt[i];
      in_last_byte <= (i == pkt.size() - 1);
      @(posedge clk);
      while (full) @(posedge clk);
      @(negedge clk);
      bytes_sent++;
    end
    packets_sent++;
  endtask

  // short sentence that ends on its last date digit
  task automatic rmc_case(int hh, int mi, int ss, int dd, int mo, int yy,
                          logic [7:0] fix, bit star_early);
    make_rmc(0, hh, mi, ss, dd, mo, yy, fix, star_early, 0);
    set_length(date_at + 6);
    send_packet();
    rmc_sent++;
  endtask

  // hold the sender until every predicted result has been popped
  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
  endtask

  // result side: random stalls with stretches of steady popping
  initial begin
    int  n;
    int  served;
    bit  steady;
    served = 0;
    steady = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (served % 16 == 0) steady = ($urandom_range(0, 2) == 0);
      n = steady ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        pop <= 1'b0;
        repeat (n) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
      served++;
    end
  end

  // stimulus and verdict
  initial begin
    int k;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes of every decoded value
    rmc_case(23, 59, 59, 31, 12, 99, CH_A, 1'b0);
    rmc_case(0, 0, 0, 1, 1, 0, CH_A, 1'b0);
    // invalid fix winning over a bad hour
    rmc_case(99, 30, 30, 15, 6, 24, CH_V, 1'b0);
    // star before the ninth comma
    rmc_case(12, 30, 30, 15, 6, 24, CH_A, 1'b1);
    drain();
    // ninth comma one byte inside the scan limit, negative year from a non-digit
    make_rmc(274, 1, 2, 3, 4, 5, 6, CH_A, 1'b0, 0);
    pkt[date_at + 4] = CH_SLASH;
    set_length(date_at + 6);
    send_packet();
    rmc_sent++;
    // ninth comma on the scan limit, packet running past its nominal size
    make_rmc(275, 12, 30, 30, 15, 6, 24, CH_A, 1'b0, 0);
    set_length(PACKET_SIZE_DEF + 8);
    send_packet();
    rmc_sent++;
    // one-byte packets with all-ones and all-zeros data
    pkt.delete();
    pkt.push_back(8'hFF);
    send_packet();
    pkt.delete();
    pkt.push_back(8'h00);
    send_packet();
    drain();

    // short junk packets, mostly back to back, to fill the record queue
    for (k = 0; k < 20; k++) begin
      burst = ($urandom_range(0, 3) != 0);
      make_noise($urandom_range(1, 3));
      send_packet();
      if (k == 9) drain();
    end

    push <= 1'b0;
    k = 0;
    while (results_due != 0 && k < 5000) begin
      @(negedge clk);
      k++;
    end
    repeat (20) @(negedge clk);

    $display("sent %0d bytes in %0d packets (%0d rmc sentences), gaps and bursts",
             bytes_sent, packets_sent, rmc_sent);
    $display("checked results: %0d ok, %0d bad fix, %0d no date, %0d out of range",
             ok_count, fix_count, nodate_count, range_count);
    if (mismatches == 0 && results_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, results_due);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
